// ===== sv/deq_pkg.sv =====
package deq_pkg;

    // Fixed widths of the request and result fields.
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int TARGET_W = 9;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 9;

    // Operation codes carried in the request's tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_FIND       = 3'd4,
        KIND_RESIZE     = 3'd5
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // One result item.
    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   end_value;
        logic                 end_valid;
        logic [POS_W-1:0]     match_position;
        logic [COUNT_W-1:0]   element_count;
        logic                 queue_empty;
    } res_t;

endpackage

// ===== sv/deq_ram.sv =====
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one read port with registered read data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/double_ended_queue_core.sv =====
// Bounded double-ended queue of signed words, held as a ring in one memory.
// Requests arrive on the s_ stream: tuser carries the operation (push back,
// push front, pop front, pop back, find, resize) and tdata the value or key
// and the resize target. Every request gives exactly one result on the m_
// stream: status in tuser, and the end value, its valid flag, the match
// position, the element count and the empty flag in tdata.
// Pushes, refused requests, unused codes, finds on an empty queue, and pops
// or shrinking resizes that leave the queue empty are answered from the idle
// state directly, so they can follow each other in consecutive cycles while
// the receiver takes each result. Other pops and non-growing
// resizes pass through ST_READ, as the new end word comes through the
// memory's registered read. Any other find walks ST_FIND: the memory port
// reads one element a cycle from the front. A growing resize stays in
// ST_GROW, as each zero word is a separate memory write.
// The result sits in an output register; a new request is taken while that
// register is being emptied, so a stalled receiver holds up the input only
// once the register is full. Reset empties the queue and clears the output valid;
// the memory itself is not cleared, since no entry is read before written.
module double_ended_queue_core #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // item_value [31:0], target_count [40:32]
    input  logic [2:0]  s_tuser,   // kind [2:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // end_value [31:0], end_valid [32], match_position [40:33],
    // element_count [49:41], queue_empty [50]
    output logic [55:0] m_tdata,
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_SUM  = (CW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FIND,
        ST_GROW
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     front_reg, front_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     walk_reg, walk_next;
    logic [CW-1:0]     target_reg, target_next;
    deq_pkg::res_t     res_reg, res_next;
    logic              m_valid_reg, m_valid_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    deq_pkg::kind_t        in_kind;
    logic [DATA_WIDTH-1:0] in_value;
    logic [31:0]           in_target_wide;
    logic [CW-1:0]         in_target;
    logic                  accept;

    // Ring address helpers.
    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST_ADDR : a - AW'(1);
    endfunction

    // Address of the element at a given offset from the front.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] front,
                                           input logic [CW-1:0] offset);
        logic [CW:0] sum;
        sum = (CW + 1)'(front) + (CW + 1)'(offset);
        if (sum >= DEPTH_SUM) begin
            sum = sum - DEPTH_SUM;
        end
        return AW'(sum);
    endfunction

    // Sign extension of a stored word to the result width.
    function automatic logic [deq_pkg::VALUE_W-1:0] widen(input logic [DATA_WIDTH-1:0] w);
        return deq_pkg::VALUE_W'($signed(w));
    endfunction

    function automatic deq_pkg::res_t make_res(input deq_pkg::status_t st,
                                               input logic [deq_pkg::VALUE_W-1:0] v,
                                               input logic vld,
                                               input logic [AW-1:0] pos,
                                               input logic [CW-1:0] cnt);
        deq_pkg::res_t r;
        r.status         = st;
        r.end_value      = v;
        r.end_valid      = vld;
        r.match_position = deq_pkg::POS_W'(pos);
        r.element_count  = deq_pkg::COUNT_W'(cnt);
        r.queue_empty    = (cnt == '0);
        return r;
    endfunction

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Request decode; the resize target saturates at the queue depth.
    assign in_kind        = deq_pkg::kind_t'(s_tuser);
    assign in_value       = DATA_WIDTH'(s_tdata[31:0]);
    assign in_target_wide = (32'(s_tdata[40:32]) > 32'(DEPTH)) ? 32'(DEPTH)
                                                                : 32'(s_tdata[40:32]);
    assign in_target      = CW'(in_target_wide);

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // Operation sequencing: memory accesses and result formation.
    always_comb begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        idx_next     = idx_reg;
        walk_next    = walk_reg;
        target_next  = target_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_tready;
        ram_we       = 1'b0;
        ram_waddr    = front_reg;
        ram_wdata    = in_value;
        ram_raddr    = walk_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_kind)
                        deq_pkg::KIND_PUSH_BACK, deq_pkg::KIND_PUSH_FRONT: begin
                            m_valid_next = 1'b1;
                            if (count_reg == FULL_COUNT) begin
                                res_next = make_res(deq_pkg::STAT_FULL, '0, 1'b0, '0,
                                                    count_reg);
                            end else begin
                                ram_we = 1'b1;
                                if (in_kind == deq_pkg::KIND_PUSH_BACK) begin
                                    ram_waddr = slot(front_reg, count_reg);
                                end else begin
                                    ram_waddr  = addr_dec(front_reg);
                                    front_next = addr_dec(front_reg);
                                end
                                count_next = count_reg + CW'(1);
                                res_next   = make_res(deq_pkg::STAT_OK, widen(in_value),
                                                      1'b1, '0, count_reg + CW'(1));
                            end
                        end
                        deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
                            if (count_reg == '0) begin
                                m_valid_next = 1'b1;
                                res_next = make_res(deq_pkg::STAT_EMPTY, '0, 1'b0, '0,
                                                    count_reg);
                            end else begin
                                count_next = count_reg - CW'(1);
                                if (in_kind == deq_pkg::KIND_POP_FRONT) begin
                                    front_next = addr_inc(front_reg);
                                    ram_raddr  = addr_inc(front_reg);
                                end else begin
                                    ram_raddr = slot(front_reg, count_reg - CW'(2));
                                end
                                if (count_reg == CW'(1)) begin
                                    m_valid_next = 1'b1;
                                    res_next = make_res(deq_pkg::STAT_OK, '0, 1'b0, '0,
                                                        '0);
                                end else begin
                                    state_next = ST_READ;
                                end
                            end
                        end
                        deq_pkg::KIND_FIND: begin
                            key_next = in_value;
                            if (count_reg == '0) begin
                                m_valid_next = 1'b1;
                                res_next = make_res(deq_pkg::STAT_NOT_FOUND, '0, 1'b0,
                                                    '0, count_reg);
                            end else begin
                                ram_raddr  = front_reg;
                                walk_next  = addr_inc(front_reg);
                                idx_next   = '0;
                                state_next = ST_FIND;
                            end
                        end
                        deq_pkg::KIND_RESIZE: begin
                            if (in_target > count_reg) begin
                                target_next = in_target;
                                state_next  = ST_GROW;
                            end else begin
                                count_next = in_target;
                                if (in_target == '0) begin
                                    m_valid_next = 1'b1;
                                    res_next = make_res(deq_pkg::STAT_OK, '0, 1'b0, '0,
                                                        '0);
                                end else begin
                                    ram_raddr  = slot(front_reg, in_target - CW'(1));
                                    state_next = ST_READ;
                                end
                            end
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            res_next = make_res(deq_pkg::STAT_OK, '0, 1'b0, '0,
                                                count_reg);
                        end
                    endcase
                end
            end
            ST_READ: begin
                // The new end word arrives from the memory.
                m_valid_next = 1'b1;
                res_next     = make_res(deq_pkg::STAT_OK, widen(ram_rdata), 1'b1, '0,
                                        count_reg);
                state_next   = ST_IDLE;
            end
            ST_FIND: begin
                // The word at idx_reg arrives while the next one is read.
                ram_raddr = walk_reg;
                walk_next = addr_inc(walk_reg);
                if (ram_rdata == key_reg) begin
                    m_valid_next = 1'b1;
                    res_next = make_res(deq_pkg::STAT_OK, widen(ram_rdata), 1'b1,
                                        idx_reg, count_reg);
                    state_next = ST_IDLE;
                end else if ((CW'(idx_reg) + CW'(1)) == count_reg) begin
                    m_valid_next = 1'b1;
                    res_next = make_res(deq_pkg::STAT_NOT_FOUND, '0, 1'b0, '0,
                                        count_reg);
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_GROW: begin
                // One zero word is added at the front each cycle.
                ram_we     = 1'b1;
                ram_waddr  = addr_dec(front_reg);
                ram_wdata  = '0;
                front_next = addr_dec(front_reg);
                count_next = count_reg + CW'(1);
                if ((count_reg + CW'(1)) == target_reg) begin
                    m_valid_next = 1'b1;
                    res_next = make_res(deq_pkg::STAT_OK, '0, 1'b1, '0,
                                        count_reg + CW'(1));
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        walk_reg   <= walk_next;
        target_reg <= target_next;
        res_reg    <= res_next;
    end

    // Result packing.
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {5'b0, res_reg.queue_empty, res_reg.element_count,
                       res_reg.match_position, res_reg.end_valid, res_reg.end_value};

endmodule
